// File: sv/skvt_pkg.sv
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned DATA_BITS_DEF = 32;
  localparam int unsigned KEY_BITS      = 64;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISSING  = 3'd3,
    ST_REPLACED = 3'd4
  } status_t;

endpackage

// File: sv/skvt_if.sv
interface skvt_req_if #(
  parameter int unsigned DATA_BITS = skvt_pkg::DATA_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [skvt_pkg::KEY_BITS-1:0] key;
  logic [DATA_BITS-1:0]          data_in;

  modport source (output valid, func, key, data_in, input ready);
  modport sink   (input valid, func, key, data_in, output ready);
endinterface

interface skvt_rsp_if #(
  parameter int unsigned DATA_BITS = skvt_pkg::DATA_BITS_DEF,
  parameter int unsigned CNT_BITS  = 7
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [DATA_BITS-1:0] data_out;
  logic [CNT_BITS-1:0]  entry_count;

  modport source (output valid, status, data_out, entry_count, input ready);
  modport sink   (input valid, status, data_out, entry_count, output ready);
endinterface

// File: sv/sorted_key_value_table_core.sv
// Bounded ordered map of up to CAPACITY entries, kept sorted by ascending 64-bit key in one
// single-port-write, registered-read memory; every request word yields exactly one result word
// with a status, a data word and the entry count after the request. A request first runs a
// binary search, each step a memory read in S_SEARCH and a compare in S_CMP, then a state that
// closes the search and a probe state; an insert or a remove then moves every entry above
// the slot, each moved entry a memory read and a write back, plus one closing step, and
// S_FINISH loads the result register once the output register is empty or being taken. Get,
// set of an existing key and failed requests therefore skip the shift, while inserts and
// removes grow with the number of entries above the slot. The next word is accepted in
// S_IDLE, after the result is loaded. One request is in work at a time; the next may be
// accepted while the previous result still waits on the output register.
module sorted_key_value_table_core #(
  parameter int unsigned CAPACITY  = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_BITS = skvt_pkg::DATA_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  skvt_req_if.sink   in_ch,
  skvt_rsp_if.source out_ch
);
  import skvt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_BITS + DATA_BITS;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_PROBE  = 9'b000001000,
    S_SHUP   = 9'b000010000,
    S_SHUPWR = 9'b000100000,
    S_SHDN   = 9'b001000000,
    S_SHDNWR = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [CW-1:0] mid;
  logic [1:0] func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [DATA_BITS-1:0] din_r, din_nxt;
  logic [2:0] res_status_r, res_status_nxt;
  logic [DATA_BITS-1:0] res_data_r, res_data_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic [KEY_BITS-1:0] rkey;
  logic [DATA_BITS-1:0] rdat;
  logic hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rkey = rdata_r[EW-1:DATA_BITS];
  assign rdat = rdata_r[DATA_BITS-1:0];
  assign mid  = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign hit  = (lo_r < count_r) && (rkey == key_r);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    din_nxt        = din_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    waddr          = lo_r[AW-1:0];
    wdata          = {key_r, din_r};
    raddr          = lo_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          key_nxt   = in_ch.key;
          din_nxt   = in_ch.data_in;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          raddr     = mid[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_CMP: begin
        if (rkey < key_r) begin
          lo_nxt = mid + CW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SEARCH;
      end
      S_PROBE: begin
        res_data_nxt   = '0;
        res_status_nxt = ST_DONE;
        state_nxt      = S_FINISH;
        case (func_r)
          FUNC_GET: begin
            if (hit) begin
              res_data_nxt = rdat;
            end else begin
              res_status_nxt = ST_MISSING;
            end
          end
          FUNC_REMOVE: begin
            if (hit) begin
              res_data_nxt = rdat;
              idx_nxt      = lo_r;
              state_nxt    = S_SHDN;
            end else begin
              res_status_nxt = ST_MISSING;
            end
          end
          default: begin
            if (hit) begin
              if (func_r == FUNC_SET) begin
                we             = 1'b1;
                res_data_nxt   = rdat;
                res_status_nxt = ST_REPLACED;
              end else begin
                res_status_nxt = ST_EXISTS;
              end
            end else if (count_r >= CAP_C) begin
              res_status_nxt = ST_FULL;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_SHUP;
            end
          end
        endcase
      end
      S_SHUP: begin
        if (idx_r > lo_r) begin
          raddr     = AW'(idx_r - CW'(1));
          state_nxt = S_SHUPWR;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_SHUPWR: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        wdata     = rdata_r;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SHUP;
      end
      S_SHDN: begin
        if ((idx_r + CW'(1)) < count_r) begin
          raddr     = AW'(idx_r + CW'(1));
          state_nxt = S_SHDNWR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_SHDNWR: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        wdata     = rdata_r;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SHDN;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    din_r        <= din_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count exceeds capacity");

  a_count_only_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SHUP && state_r != S_SHDN) |=> $stable(count_r))
    else $error("entry count changed outside a shift");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_CMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search bounds out of order");

  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ch.ready) && state_r == S_FINISH |=> out_valid_r)
    else $error("finished word not presented");

endmodule

// File: test/sorted_key_value_table_core_tb.sv
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int CAP = 64;
  localparam int DBITS = 32;

  typedef struct {
    func_t       op;
    logic [63:0] key;
    logic [31:0] din;
    bit          typed;
    status_t     st;
    logic [31:0] dout;
    logic [6:0]  cnt;
  } stim_row_t;

  typedef struct {
    status_t     st;
    logic [31:0] dout;
    logic [6:0]  cnt;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  skvt_req_if #(.DATA_BITS(DBITS)) req_ch ();
  skvt_rsp_if #(.DATA_BITS(DBITS)) rsp_ch ();

  sorted_key_value_table_core #(.CAPACITY(CAP), .DATA_BITS(DBITS)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(rsp_ch.source)
  );

  always #5 clk = ~clk;

  logic [63:0] map_keys[$];
  logic [31:0] map_data[$];
  map_result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  logic [63:0] used_keys[$];

  function automatic map_result_t map_apply(func_t op, logic [63:0] k, logic [31:0] d);
    map_result_t r;
    int pos;
    bit hit;
    pos = 0;
    while (pos < map_keys.size() && map_keys[pos] < k) pos++;
    hit = pos < map_keys.size() && map_keys[pos] == k;
    r.st = ST_DONE;
    r.dout = '0;
    case (op)
      FUNC_ADD, FUNC_SET: begin
        if (hit && op == FUNC_ADD) begin
          r.st = ST_EXISTS;
        end else if (hit) begin
          r.st = ST_REPLACED;
          r.dout = map_data[pos];
          map_data[pos] = d;
        end else if (map_keys.size() >= CAP) begin
          r.st = ST_FULL;
        end else begin
          map_keys.insert(pos, k);
          map_data.insert(pos, d);
        end
      end
      default: begin
        if (!hit) begin
          r.st = ST_MISSING;
        end else begin
          r.dout = map_data[pos];
          if (op == FUNC_REMOVE) begin
            map_keys.delete(pos);
            map_data.delete(pos);
          end
        end
      end
    endcase
    r.cnt = 7'(map_keys.size());
    return r;
  endfunction

  task automatic send_word(func_t op, logic [63:0] k, logic [31:0] d);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= op;
    req_ch.key <= k;
    req_ch.data_in <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(map_apply(op, k, d));
    used_keys.push_back(k);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: k = 64'($urandom_range(0, 40));
      default: k = used_keys.size() ? used_keys[$urandom_range(0, used_keys.size() - 1)]
                                     : 64'd0;
    endcase
    return k;
  endfunction

  always @(posedge clk) begin
    map_result_t e;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp_ch.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.data_out !== e.dout) begin
          $error("data_out expected %h actual %h", e.dout, rsp_ch.data_out);
          errors++;
        end
        if (rsp_ch.entry_count !== e.cnt) begin
          $error("entry_count expected %0d actual %0d", e.cnt, rsp_ch.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  stim_row_t rows[] = '{
    '{FUNC_GET,    64'd0,          32'h0,        1, ST_MISSING,  32'h0,        7'd0},
    '{FUNC_REMOVE, '1,             32'h0,        1, ST_MISSING,  32'h0,        7'd0},
    '{FUNC_ADD,    64'd0,          32'h0,        1, ST_DONE,     32'h0,        7'd1},
    '{FUNC_ADD,    '1,             32'hffffffff, 1, ST_DONE,     32'h0,        7'd2},
    '{FUNC_ADD,    '1,             32'h1234,     1, ST_EXISTS,   32'h0,        7'd2},
    '{FUNC_GET,    '1,             32'h0,        1, ST_DONE,     32'hffffffff, 7'd2},
    '{FUNC_GET,    64'd0,          32'h5,        1, ST_DONE,     32'h0,        7'd2},
    '{FUNC_SET,    64'd0,          32'ha5a5a5a5, 1, ST_REPLACED, 32'h0,        7'd2},
    '{FUNC_SET,    64'h8000000000000000, 32'h1,  1, ST_DONE,     32'h0,        7'd3},
    '{FUNC_GET,    64'h7fffffffffffffff, 32'h0,  1, ST_MISSING,  32'h0,        7'd3},
    '{FUNC_SET,    64'h8000000000000000, 32'h2,  1, ST_REPLACED, 32'h1,        7'd3},
    '{FUNC_REMOVE, 64'h8000000000000000, 32'h0,  1, ST_DONE,     32'h2,        7'd2},
    '{FUNC_REMOVE, 64'd0,          32'h0,        1, ST_DONE,     32'ha5a5a5a5, 7'd1},
    '{FUNC_ADD,    64'h5555555555555555, 32'h55555555, 0, ST_DONE, 32'h0, 7'd0},
    '{FUNC_GET,    64'h5555555555555555, 32'h0,  0, ST_DONE,     32'h0,        7'd0},
    '{FUNC_REMOVE, '1,             32'h0,        0, ST_DONE,     32'h0,        7'd0}
  };

  initial begin
    logic [63:0] k;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_GET;
    req_ch.key = '0;
    req_ch.data_in = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].op, rows[i].key, rows[i].din);
      if (rows[i].typed) begin
        if (pending_results[$].st != rows[i].st ||
            pending_results[$].dout != rows[i].dout ||
            pending_results[$].cnt != rows[i].cnt) begin
          $error("table row %0d disagrees with predictor", i);
          errors++;
        end
      end
    end

    // Fill the table past capacity, then hold the output off while words keep coming.
    for (int i = 0; i < 70; i++) begin
      if (i == 60) hold_off = 1'b1;
      send_word($urandom_range(0, 1) ? FUNC_ADD : FUNC_SET, {$urandom, $urandom}, $urandom);
    end
    for (int i = 0; i < 20; i++) send_word(FUNC_GET, pick_key(), $urandom);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    for (int i = 0; i < 640; i++) begin
      if (i == 560) calm = 1'b1;
      k = pick_key();
      if (map_keys.size() > 48) begin
        send_word($urandom_range(0, 4) ? FUNC_REMOVE : func_t'($urandom_range(0, 3)),
                  k, $urandom);
      end else begin
        send_word(func_t'($urandom_range(0, 3)), k, $urandom);
      end
    end
    while (map_keys.size() != 0) begin
      send_word(FUNC_REMOVE, map_keys[$urandom_range(0, map_keys.size() - 1)], $urandom);
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("PASS sorted_key_value_table_core");
    else $display("FAIL sorted_key_value_table_core");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL sorted_key_value_table_core");
    $finish;
  end

endmodule
